// ----- src/srq_pkg.sv -----
// Shared types and constants for the session request ingest queue.
`default_nettype none

package srq_pkg;

    localparam logic [4:0] HS_BYTES         = 5'd21;
    localparam logic [4:0] REQ_LAST_IDX     = 5'd3;
    localparam logic [7:0] HS_OPCODE        = 8'd15;
    localparam logic [31:0] DEFAULT_REVISION = 32'd239;
    localparam logic [8:0] DEFAULT_LANE_LIMIT = 9'd200;

    localparam logic [7:0] OP_NORMAL = 8'd0;
    localparam logic [7:0] OP_URGENT = 8'd1;
    localparam logic [7:0] OP_LOGIN  = 8'd2;
    localparam logic [7:0] OP_LOGOUT = 8'd3;
    localparam logic [7:0] OP_KEY    = 8'd4;

    localparam logic [1:0] CFG_EXP_REV     = 2'd0;
    localparam logic [1:0] CFG_SERVER_FULL = 2'd1;
    localparam logic [1:0] CFG_LANE_LIMIT  = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_OUT_OF_DATE = 2'd1;
    localparam logic [1:0] ST_SERVER_FULL = 2'd2;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_PROTOCOL   = 2'd1;
    localparam logic [1:0] ERR_QUEUE_FULL = 2'd2;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [2:0] {
        PH_HANDSHAKE = 3'd0,
        PH_ACTIVE    = 3'd1,
        PH_CLOSING   = 3'd2,
        PH_CLOSED    = 3'd3,
        PH_FAILED    = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        EV_ABSORBED  = 3'd0,
        EV_HANDSHAKE = 3'd1,
        EV_POPPED    = 3'd2,
        EV_NONE      = 3'd3,
        EV_FAILED    = 3'd4,
        EV_REJECTED  = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_OUT  = 2'd2
    } t_ctrl_state;

    typedef struct packed {
        logic take;
        logic load_pop;
    } t_dp_cmd;

    typedef struct packed {
        logic pop_hit;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- src/srq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/srq_ctrl.sv -----
// Controller state machine that sequences accept, queue read and result hand-off.
`default_nettype none

module srq_ctrl
    import srq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.take     = 1'b0;
        o_cmd.load_pop = 1'b0;
        o_in_stall     = 1'b1;
        o_out_valid    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_sts.pop_hit ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                o_cmd.load_pop = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/srq_dp.sv -----
// Datapath: session state, frame decoding, two priority queues and result registers.
`default_nettype none

module srq_dp
    import srq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_sts          o_sts,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic      [2:0]  o_event_res,
    output logic      [1:0]  o_status_code,
    output logic      [1:0]  o_error_code,
    output logic      [7:0]  o_archive,
    output logic      [15:0] o_group,
    output logic      [7:0]  o_mask_key,
    output logic             o_login_flag,
    output logic      [2:0]  o_session_phase
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = (FW > 9) ? FW : 9;
    localparam int SW = FW + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX  = FW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_SW  = SW'(QUEUE_DEPTH);

    logic [31:0]   r_exp_rev;
    logic          r_server_full;
    logic [8:0]    r_lane_limit;

    t_phase        r_phase, n_phase;
    logic [4:0]    r_fc, n_fc;
    logic [31:0]   r_acc, n_acc;
    logic [7:0]    r_fb [3];
    logic [7:0]    n_fb [3];
    logic [7:0]    r_key, n_key;
    logic          r_login, n_login;
    logic [AW-1:0] r_uhead, n_uhead, r_nhead, n_nhead;
    logic [FW-1:0] r_ufill, n_ufill, r_nfill, n_nfill;

    t_event        r_event, n_event;
    logic [1:0]    r_status, n_status;
    logic [1:0]    r_error, n_error;
    logic [7:0]    r_archive;
    logic [15:0]   r_group;
    logic [7:0]    r_mask_key;
    logic          r_pop_urgent, n_pop_urgent;

    logic          u_we, q_we, u_re, q_re;
    logic [AW-1:0] u_tail, q_tail;
    logic [31:0]   push_word;
    logic [31:0]   u_rdata, q_rdata;
    logic          u_full, q_full;
    logic [SW-1:0] u_sum, q_sum;
    logic [4:0]    fc_inc;
    logic [7:0]    op;

    always_comb begin
        u_sum  = SW'(r_uhead) + SW'(r_ufill);
        q_sum  = SW'(r_nhead) + SW'(r_nfill);
        u_tail = (u_sum >= DEPTH_SW) ? AW'(u_sum - DEPTH_SW) : AW'(u_sum);
        q_tail = (q_sum >= DEPTH_SW) ? AW'(q_sum - DEPTH_SW) : AW'(q_sum);
        u_full = (CW'(r_ufill) >= CW'(r_lane_limit)) || (r_ufill == FILL_MAX);
        q_full = (CW'(r_nfill) >= CW'(r_lane_limit)) || (r_nfill == FILL_MAX);
    end

    assign push_word = {r_key, r_fb[2], i_rx_byte, r_fb[1]};
    assign fc_inc    = r_fc + 5'd1;
    assign op        = r_fb[0];

    always_comb begin
        n_phase      = r_phase;
        n_fc         = r_fc;
        n_acc        = r_acc;
        n_fb         = r_fb;
        n_key        = r_key;
        n_login      = r_login;
        n_uhead      = r_uhead;
        n_nhead      = r_nhead;
        n_ufill      = r_ufill;
        n_nfill      = r_nfill;
        n_event      = EV_ABSORBED;
        n_status     = ST_OK;
        n_error      = ERR_NONE;
        n_pop_urgent = 1'b0;
        u_we         = 1'b0;
        q_we         = 1'b0;
        u_re         = 1'b0;
        q_re         = 1'b0;
        o_sts.pop_hit = 1'b0;

        if (i_func == FUNC_BYTE) begin
            unique case (r_phase)
                PH_HANDSHAKE: begin
                    if (r_fc == 5'd0 && i_rx_byte != HS_OPCODE) begin
                        n_phase = PH_FAILED;
                        n_fc    = 5'd0;
                        n_error = ERR_PROTOCOL;
                        n_event = EV_FAILED;
                    end else begin
                        if (r_fc >= 5'd1 && r_fc <= 5'd4) begin
                            n_acc = {r_acc[23:0], i_rx_byte};
                        end
                        n_fc = fc_inc;
                        if (fc_inc >= HS_BYTES) begin
                            priority if (r_server_full) begin
                                n_status = ST_SERVER_FULL;
                            end else if (r_acc != r_exp_rev) begin
                                n_status = ST_OUT_OF_DATE;
                            end else begin
                                n_status = ST_OK;
                            end
                            n_phase = (n_status == ST_OK) ? PH_ACTIVE : PH_CLOSING;
                            n_fc    = 5'd0;
                            n_acc   = 32'd0;
                            n_event = EV_HANDSHAKE;
                        end
                    end
                end
                PH_ACTIVE: begin
                    if (r_fc < REQ_LAST_IDX) begin
                        n_fb[r_fc[1:0]] = i_rx_byte;
                        n_fc            = fc_inc;
                    end else begin
                        n_fc = 5'd0;
                        priority if (op == OP_LOGIN || op == OP_LOGOUT) begin
                            if (r_fb[1] != 8'd0 || r_fb[2] != 8'd0 || i_rx_byte != 8'd0) begin
                                n_phase = PH_FAILED;
                                n_error = ERR_PROTOCOL;
                                n_event = EV_FAILED;
                            end else begin
                                n_login = (op == OP_LOGIN);
                            end
                        end else if (op == OP_KEY) begin
                            if (r_fb[2] != 8'd0 || i_rx_byte != 8'd0) begin
                                n_phase = PH_FAILED;
                                n_error = ERR_PROTOCOL;
                                n_event = EV_FAILED;
                            end else begin
                                n_key = r_fb[1];
                            end
                        end else if (op == OP_URGENT) begin
                            if (u_full) begin
                                n_phase = PH_FAILED;
                                n_error = ERR_QUEUE_FULL;
                                n_event = EV_FAILED;
                            end else begin
                                u_we    = i_cmd.take;
                                n_ufill = r_ufill + FW'(1);
                            end
                        end else if (op == OP_NORMAL) begin
                            if (q_full) begin
                                n_phase = PH_FAILED;
                                n_error = ERR_QUEUE_FULL;
                                n_event = EV_FAILED;
                            end else begin
                                q_we    = i_cmd.take;
                                n_nfill = r_nfill + FW'(1);
                            end
                        end else begin
                            n_phase = PH_FAILED;
                            n_error = ERR_PROTOCOL;
                            n_event = EV_FAILED;
                        end
                    end
                end
                default: begin
                    n_event = EV_REJECTED;
                end
            endcase
        end else begin
            priority if (r_phase == PH_FAILED || r_phase == PH_CLOSED) begin
                n_event = EV_REJECTED;
            end else if (r_ufill != '0) begin
                o_sts.pop_hit = 1'b1;
                u_re          = i_cmd.take;
                n_pop_urgent  = 1'b1;
                n_uhead       = (r_uhead == LAST_ADDR) ? '0 : r_uhead + AW'(1);
                n_ufill       = r_ufill - FW'(1);
                n_event       = EV_POPPED;
            end else if (r_nfill != '0) begin
                o_sts.pop_hit = 1'b1;
                q_re          = i_cmd.take;
                n_nhead       = (r_nhead == LAST_ADDR) ? '0 : r_nhead + AW'(1);
                n_nfill       = r_nfill - FW'(1);
                n_event       = EV_POPPED;
            end else begin
                n_event = EV_NONE;
                if (r_phase == PH_CLOSING) begin
                    n_phase = PH_CLOSED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_rev     <= DEFAULT_REVISION;
            r_server_full <= 1'b0;
            r_lane_limit  <= DEFAULT_LANE_LIMIT;
            r_phase       <= PH_HANDSHAKE;
            r_fc          <= 5'd0;
            r_acc         <= 32'd0;
            r_fb          <= '{default: 8'd0};
            r_key         <= 8'd0;
            r_login       <= 1'b0;
            r_uhead       <= '0;
            r_nhead       <= '0;
            r_ufill       <= '0;
            r_nfill       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_EXP_REV:     r_exp_rev     <= i_cfg_data;
                    CFG_SERVER_FULL: r_server_full <= i_cfg_data[0];
                    CFG_LANE_LIMIT:  r_lane_limit  <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (i_cmd.take) begin
                r_phase <= n_phase;
                r_fc    <= n_fc;
                r_acc   <= n_acc;
                r_fb    <= n_fb;
                r_key   <= n_key;
                r_login <= n_login;
                r_uhead <= n_uhead;
                r_nhead <= n_nhead;
                r_ufill <= n_ufill;
                r_nfill <= n_nfill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_event      <= n_event;
            r_status     <= n_status;
            r_error      <= n_error;
            r_pop_urgent <= n_pop_urgent;
            r_archive    <= 8'd0;
            r_group      <= 16'd0;
            r_mask_key   <= 8'd0;
        end else if (i_cmd.load_pop) begin
            r_archive  <= r_pop_urgent ? u_rdata[7:0]   : q_rdata[7:0];
            r_group    <= r_pop_urgent ? u_rdata[23:8]  : q_rdata[23:8];
            r_mask_key <= r_pop_urgent ? u_rdata[31:24] : q_rdata[31:24];
        end
    end

    srq_ram #(
        .WIDTH (32),
        .DEPTH (QUEUE_DEPTH)
    ) u_urgent_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_tail),
        .i_wdata (push_word),
        .i_re    (u_re),
        .i_raddr (r_uhead),
        .o_rdata (u_rdata)
    );

    srq_ram #(
        .WIDTH (32),
        .DEPTH (QUEUE_DEPTH)
    ) u_normal_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_tail),
        .i_wdata (push_word),
        .i_re    (q_re),
        .i_raddr (r_nhead),
        .o_rdata (q_rdata)
    );

    assign o_event_res     = r_event;
    assign o_status_code   = r_status;
    assign o_error_code    = r_error;
    assign o_archive       = r_archive;
    assign o_group         = r_group;
    assign o_mask_key      = r_mask_key;
    assign o_login_flag    = r_login;
    assign o_session_phase = r_phase;

endmodule

`default_nettype wire

// ----- src/session_request_ingest_queue_unit.sv -----
// Top level of the session request ingest queue: controller, datapath and checks.
//
// One word at a time: a received byte or a pop request is accepted only while the
// unit is idle, and its single result word is held until the consumer takes it.
// A byte, or a pop that finds nothing to serve, goes from the idle state straight to
// the output state; a pop that returns a queued request passes through a read state
// first, which waits on the registered read of the queue RAM. Each priority queue
// is a QUEUE_DEPTH-entry RAM with head and fill registers, so no clearing pass is
// needed after reset. Configuration writes are always taken and must be issued only
// while no word is in flight.
`default_nettype none

module session_request_ingest_queue_unit
    import srq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [2:0]  o_event_res,
    output logic      [1:0]  o_status_code,
    output logic      [1:0]  o_error_code,
    output logic      [7:0]  o_archive,
    output logic      [15:0] o_group,
    output logic      [7:0]  o_mask_key,
    output logic             o_login_flag,
    output logic      [2:0]  o_session_phase,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    srq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    srq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_func          (i_func),
        .i_rx_byte       (i_rx_byte),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_event_res     (o_event_res),
        .o_status_code   (o_status_code),
        .o_error_code    (o_error_code),
        .o_archive       (o_archive),
        .o_group         (o_group),
        .o_mask_key      (o_mask_key),
        .o_login_flag    (o_login_flag),
        .o_session_phase (o_session_phase)
    );

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result word is pending");

    a_status_only_handshake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != EV_HANDSHAKE) |-> (o_status_code == ST_OK))
        else $error("handshake status reported outside a handshake result");

    a_error_only_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != EV_FAILED) |-> (o_error_code == ERR_NONE))
        else $error("error cause reported outside a failure result");

    a_failed_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res == EV_FAILED) |-> (o_session_phase == PH_FAILED))
        else $error("failure result without the failed session phase");

endmodule

`default_nettype wire

// ----- tb/session_request_checker.sv -----
// Checker for the session request ingest queue: predicts every result word and compares it.
module session_request_checker
    import srq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_event_res,
    input  logic [1:0]  i_status_code,
    input  logic [1:0]  i_error_code,
    input  logic [7:0]  i_archive,
    input  logic [15:0] i_group,
    input  logic [7:0]  i_mask_key,
    input  logic        i_login_flag,
    input  logic [2:0]  i_session_phase,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 256;
    localparam logic [4:0] REV_LAST_BYTE = 5'd4;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_event      ev;
        logic [1:0]  status;
        logic [1:0]  err;
        logic [7:0]  archive;
        logic [15:0] group;
        logic [7:0]  key;
        logic        login;
        t_phase      phase;
    } t_session_word;

    logic [31:0] cfg_rev;
    logic        cfg_full;
    logic [8:0]  cfg_limit;

    t_phase      phase_q;
    logic [4:0]  frame_idx;
    logic [31:0] rev_acc;
    logic [7:0]  frame_b [0:2];
    logic [7:0]  key_q;
    logic        login_q;
    logic [31:0] urgent_ring [0:RING_DEPTH-1];
    logic [31:0] normal_ring [0:RING_DEPTH-1];
    logic [7:0]  urgent_head;
    logic [7:0]  normal_head;
    logic [8:0]  urgent_fill;
    logic [8:0]  normal_fill;

    t_session_word expected_words [$];
    int            fails;

    function automatic string word_text(t_session_word w);
        return $sformatf("event=%0d status=%0d error=%0d archive=%0d group=%0d key=%0d %s%0d %s%0d",
                         w.ev, w.status, w.err, w.archive, w.group, w.key,
                         "login=", w.login, "phase=", w.phase);
    endfunction

    function automatic void fail_session(inout t_session_word w, input logic [1:0] cause);
        phase_q = PH_FAILED;
        frame_idx = '0;
        w.ev = EV_FAILED;
        w.err = cause;
    endfunction

    function automatic logic push_fetch(input logic urgent, input logic [31:0] entry);
        logic [8:0] cap;
        logic [7:0] tail;
        cap = (cfg_limit > 9'd256) ? 9'd256 : cfg_limit;
        if (urgent) begin
            if (urgent_fill >= cap) return 1'b0;
            tail = urgent_head + urgent_fill[7:0];
            urgent_ring[tail] = entry;
            urgent_fill++;
        end else begin
            if (normal_fill >= cap) return 1'b0;
            tail = normal_head + normal_fill[7:0];
            normal_ring[tail] = entry;
            normal_fill++;
        end
        return 1'b1;
    endfunction

    function automatic t_session_word advance_session(input logic func, input logic [7:0] rx);
        t_session_word w;
        logic [31:0]   entry;
        logic [7:0]    op;
        w = '0;
        w.ev = EV_ABSORBED;
        if (func == FUNC_BYTE) begin
            case (phase_q)
                PH_HANDSHAKE: begin
                    if (frame_idx == 5'd0 && rx != HS_OPCODE) begin
                        fail_session(w, ERR_PROTOCOL);
                    end else begin
                        if (frame_idx >= 5'd1 && frame_idx <= REV_LAST_BYTE) begin
                            rev_acc = {rev_acc[23:0], rx};
                        end
                        frame_idx++;
                        if (frame_idx >= HS_BYTES) begin
                            if (cfg_full) begin
                                w.status = ST_SERVER_FULL;
                            end else if (rev_acc != cfg_rev) begin
                                w.status = ST_OUT_OF_DATE;
                            end else begin
                                w.status = ST_OK;
                            end
                            phase_q = (w.status == ST_OK) ? PH_ACTIVE : PH_CLOSING;
                            frame_idx = '0;
                            rev_acc = '0;
                            w.ev = EV_HANDSHAKE;
                        end
                    end
                end
                PH_ACTIVE: begin
                    if (frame_idx < REQ_LAST_IDX) begin
                        frame_b[frame_idx[1:0]] = rx;
                        frame_idx++;
                    end else begin
                        op = frame_b[0];
                        frame_idx = '0;
                        case (op)
                            OP_LOGIN, OP_LOGOUT: begin
                                if (frame_b[1] != 8'd0 || frame_b[2] != 8'd0 || rx != 8'd0) begin
                                    fail_session(w, ERR_PROTOCOL);
                                end else begin
                                    login_q = (op == OP_LOGIN);
                                end
                            end
                            OP_KEY: begin
                                if (frame_b[2] != 8'd0 || rx != 8'd0) begin
                                    fail_session(w, ERR_PROTOCOL);
                                end else begin
                                    key_q = frame_b[1];
                                end
                            end
                            OP_NORMAL, OP_URGENT: begin
                                entry = {key_q, frame_b[2], rx, frame_b[1]};
                                if (!push_fetch(op == OP_URGENT, entry)) begin
                                    fail_session(w, ERR_QUEUE_FULL);
                                end
                            end
                            default: begin
                                fail_session(w, ERR_PROTOCOL);
                            end
                        endcase
                    end
                end
                default: begin
                    w.ev = EV_REJECTED;
                end
            endcase
        end else if (phase_q == PH_FAILED || phase_q == PH_CLOSED) begin
            w.ev = EV_REJECTED;
        end else if (urgent_fill != 9'd0 || normal_fill != 9'd0) begin
            if (urgent_fill != 9'd0) begin
                entry = urgent_ring[urgent_head];
                urgent_head++;
                urgent_fill--;
            end else begin
                entry = normal_ring[normal_head];
                normal_head++;
                normal_fill--;
            end
            w.ev = EV_POPPED;
            w.archive = entry[7:0];
            w.group = entry[23:8];
            w.key = entry[31:24];
        end else begin
            w.ev = EV_NONE;
            if (phase_q == PH_CLOSING) begin
                phase_q = PH_CLOSED;
            end
        end
        w.login = login_q;
        w.phase = phase_q;
        return w;
    endfunction

    initial begin
        fails = 0;
    end

    always @(posedge i_clk) begin
        t_session_word got;
        t_session_word want;
        if (!i_rst_n) begin
            cfg_rev = DEFAULT_REVISION;
            cfg_full = 1'b0;
            cfg_limit = DEFAULT_LANE_LIMIT;
            phase_q = PH_HANDSHAKE;
            frame_idx = '0;
            rev_acc = '0;
            frame_b[0] = '0;
            frame_b[1] = '0;
            frame_b[2] = '0;
            key_q = '0;
            login_q = 1'b0;
            urgent_head = '0;
            normal_head = '0;
            urgent_fill = '0;
            normal_fill = '0;
            expected_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = t_session_word'({i_event_res, i_status_code, i_error_code, i_archive,
                                       i_group, i_mask_key, i_login_flag, i_session_phase});
                if (expected_words.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT) begin
                        $display("%0t: result word with none expected: %s", $realtime,
                                 word_text(got));
                    end
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("%0t: result word mismatch", $realtime);
                            $display("    expected %s", word_text(want));
                            $display("    actual   %s", word_text(got));
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_EXP_REV:     cfg_rev = i_cfg_data;
                    CFG_SERVER_FULL: cfg_full = i_cfg_data[0];
                    CFG_LANE_LIMIT:  cfg_limit = i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_words.push_back(advance_session(i_func, i_rx_byte));
            end
        end
        o_pending <= expected_words.size();
        o_fail_count <= fails;
    end

endmodule

// ----- tb/session_request_ingest_queue_unit_test.sv -----
// Testbench top for the session request ingest queue: clock, reset, stimulus and verdict.
module session_request_ingest_queue_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srq_pkg::*;

    localparam int ITEM_TARGET = 1150;
    localparam int MAX_GAP = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT_A = 100;
    localparam int HOLD_AT_B = 700;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  event_res;
    logic [1:0]  status_code;
    logic [1:0]  error_code;
    logic [7:0]  archive;
    logic [15:0] group;
    logic [7:0]  mask_key;
    logic        login_flag;
    logic [2:0]  session_phase;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    int fail_count;
    int pending;

    int sent;
    int urgent_held;
    int normal_held;
    int lane_cap;
    int sender_calm;
    int receiver_calm;

    session_request_ingest_queue_unit u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_func         (func),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_event_res    (event_res),
        .o_status_code  (status_code),
        .o_error_code   (error_code),
        .o_archive      (archive),
        .o_group        (group),
        .o_mask_key     (mask_key),
        .o_login_flag   (login_flag),
        .o_session_phase(session_phase),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    session_request_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_func         (func),
        .i_rx_byte      (rx_byte),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_event_res    (event_res),
        .i_status_code  (status_code),
        .i_error_code   (error_code),
        .i_archive      (archive),
        .i_group        (group),
        .i_mask_key     (mask_key),
        .i_login_flag   (login_flag),
        .i_session_phase(session_phase),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    task automatic offer(input logic f, input logic [7:0] b);
        int gap;
        gap = draw_gap(sender_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
        if (f == FUNC_POP) begin
            if (urgent_held > 0) begin
                urgent_held--;
            end else if (normal_held > 0) begin
                normal_held--;
            end
        end
    endtask

    task automatic offer_pop();
        offer(FUNC_POP, 8'($urandom));
    endtask

    task automatic offer_frame(input logic [7:0] op, input logic [7:0] b1, input logic [7:0] b2,
                               input logic [7:0] b3, input int pop_pct);
        logic [7:0] bytes [0:3];
        bytes = '{op, b1, b2, b3};
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 99) < pop_pct) offer_pop();
            offer(FUNC_BYTE, bytes[i]);
        end
        if (op == OP_URGENT) begin
            urgent_held++;
        end else if (op == OP_NORMAL) begin
            normal_held++;
        end
    endtask

    task automatic offer_random_frame(input int pop_pct);
        int         pick;
        logic [7:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            op = OP_NORMAL;
        end else if (pick < 76) begin
            op = OP_URGENT;
        end else if (pick < 86) begin
            op = OP_KEY;
        end else if (pick < 93) begin
            op = OP_LOGIN;
        end else begin
            op = OP_LOGOUT;
        end
        if ((op == OP_URGENT && urgent_held >= lane_cap) ||
            (op == OP_NORMAL && normal_held >= lane_cap)) begin
            op = OP_KEY;
        end
        case (op)
            OP_NORMAL, OP_URGENT: begin
                offer_frame(op, 8'($urandom), 8'($urandom), 8'($urandom), pop_pct);
            end
            OP_KEY: begin
                offer_frame(op, 8'($urandom), 8'd0, 8'd0, pop_pct);
            end
            default: begin
                offer_frame(op, 8'd0, 8'd0, 8'd0, pop_pct);
            end
        endcase
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_LANE_LIMIT) begin
            lane_cap = (data[8:0] > 9'd256) ? 256 : int'(data[8:0]);
        end
    endtask

    task automatic set_lane_limit(input logic [8:0] limit);
        write_reg(CFG_LANE_LIMIT, {23'($urandom), limit});
    endtask

    initial begin
        int          stall_for;
        int          taken;
        out_stall = 1'b0;
        taken = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (taken == HOLD_AT_A || taken == HOLD_AT_B) begin
                stall_for = HOLD_CYCLES;
            end else begin
                stall_for = draw_gap(receiver_calm);
            end
            if (stall_for > 0) begin
                out_stall <= 1'b1;
                repeat (stall_for) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    initial begin
        int          variant;
        int          phase_no;
        int          frames;
        int          pop_pct;
        logic [7:0]  first_byte;
        logic [31:0] revision;
        logic [31:0] sent_rev;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_BYTE;
        rx_byte = 8'd0;
        cfg_valid = 1'b0;
        cfg_index = CFG_EXP_REV;
        cfg_data = 32'd0;
        sent = 0;
        urgent_held = 0;
        normal_held = 0;
        lane_cap = int'(DEFAULT_LANE_LIMIT);
        sender_calm = 0;
        receiver_calm = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Most runs open an accepted session; a few try each handshake refusal.
        variant = $urandom_range(0, 9);
        revision = $urandom;
        write_reg(CFG_EXP_REV, revision);
        write_reg(CFG_SERVER_FULL, {31'($urandom), variant == 2});
        set_lane_limit(9'd3);
        write_reg(CFG_UNUSED, $urandom);

        first_byte = HS_OPCODE;
        if (variant == 0) begin
            first_byte = $urandom_range(0, 1) ? 8'($urandom_range(0, 14))
                                              : 8'($urandom_range(16, 255));
        end
        sent_rev = revision;
        if (variant == 1 || (variant == 2 && $urandom_range(0, 1) == 1)) begin
            sent_rev = revision ^ (32'd1 << $urandom_range(0, 31));
        end
        offer_pop();
        offer(FUNC_BYTE, first_byte);
        for (int i = 3; i >= 0; i--) offer(FUNC_BYTE, sent_rev[8*i +: 8]);
        for (int i = 0; i < 16; i++) offer(FUNC_BYTE, 8'($urandom));
        offer_pop();

        if (variant > 2) begin
            offer_frame(OP_LOGIN, 8'd0, 8'd0, 8'd0, 0);
            offer_frame(OP_KEY, 8'hFF, 8'd0, 8'd0, 0);
            offer_frame(OP_URGENT, 8'hFF, 8'hFF, 8'hFF, 0);
            offer_frame(OP_KEY, 8'h00, 8'd0, 8'd0, 0);
            offer_frame(OP_NORMAL, 8'h00, 8'h00, 8'h00, 0);
            offer_frame(OP_URGENT, 8'h5A, 8'hA5, 8'h3C, 0);
            offer_frame(OP_LOGOUT, 8'd0, 8'd0, 8'd0, 0);
            repeat (4) offer_pop();

            phase_no = 0;
            while (sent < ITEM_TARGET) begin
                settle();
                case (phase_no % 6)
                    0: set_lane_limit(9'd1);
                    1: set_lane_limit(9'd256);
                    2: begin
                        set_lane_limit(9'd511);
                        write_reg(CFG_EXP_REV, 32'hFFFF_FFFF);
                    end
                    3: begin
                        set_lane_limit(9'($urandom_range(2, 40)));
                        write_reg(CFG_SERVER_FULL, {31'($urandom), 1'b1});
                    end
                    4: begin
                        write_reg(CFG_EXP_REV, 32'd0);
                        write_reg(CFG_SERVER_FULL, {31'($urandom), 1'b0});
                        set_lane_limit(DEFAULT_LANE_LIMIT);
                    end
                    default: set_lane_limit(9'($urandom_range(1, 256)));
                endcase
                pop_pct = (phase_no % 2 == 1) ? 55 : 12;
                frames = $urandom_range(20, 45);
                repeat (frames) offer_random_frame(pop_pct);
                phase_no++;
            end

            // The session ends on one of the ways a request can fail it.
            settle();
            case ($urandom_range(0, 3))
                0: begin
                    offer_frame(8'($urandom_range(5, 255)), 8'($urandom), 8'($urandom),
                                8'($urandom), 0);
                end
                1: begin
                    case ($urandom_range(0, 2))
                        0: offer_frame(OP_LOGIN, 8'($urandom_range(1, 255)), 8'd0, 8'd0, 0);
                        1: offer_frame(OP_KEY, 8'($urandom), 8'd0, 8'($urandom_range(1, 255)), 0);
                        default: offer_frame(OP_LOGOUT, 8'd0, 8'($urandom_range(1, 255)), 8'd0, 0);
                    endcase
                end
                2: begin
                    set_lane_limit(9'd0);
                    offer_frame(OP_NORMAL, 8'($urandom), 8'($urandom), 8'($urandom), 0);
                end
                default: begin
                    set_lane_limit(9'd1);
                    repeat (3) offer_frame(OP_URGENT, 8'($urandom), 8'($urandom), 8'($urandom), 0);
                end
            endcase
        end

        repeat (30) offer(1'($urandom_range(0, 1)), 8'($urandom));
        while (sent < ITEM_TARGET) offer(1'($urandom_range(0, 1)), 8'($urandom));
        settle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/srq_pkg.sv
src/srq_ram.sv
src/srq_ctrl.sv
src/srq_dp.sv
src/session_request_ingest_queue_unit.sv
tb/session_request_checker.sv
tb/session_request_ingest_queue_unit_test.sv
